@@ rtl/core/bvwt_pkg.sv @@
// ----------------------------------------------------------------------------
// bvwt_pkg
// shared widths, constants, types and helper functions of the box vertex
// world transform core
// ----------------------------------------------------------------------------
package bvwt_pkg;

   // field widths
   localparam int DATA_W      = 32;
   localparam int DIM_W       = 31;
   localparam int CORNER_W    = 2;
   localparam int NUM_CORNERS = 4;
   localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;

   // stream words
   localparam int REQ_DATA_W  = 3 * DATA_W;
   localparam int RSP_FIELD_W = CORNER_W + 4 * DATA_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // register file
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_WIDTH  = 1'b0,
      CSR_BOX_HEIGHT = 1'b1
   } csr_index_type;
   localparam logic [DIM_W-1:0] BOX_RESET = 31'd65536;

   // angle reduction: 360 deg in Q16.16 is 45 * 2^19
   localparam int MOD_SHIFT   = 19;
   localparam int MOD_BASE    = 45;
   localparam int MOD_OFFSET  = 45 * 92;
   localparam int MOD_U_W     = 14;
   localparam int RECIP       = (1 << MOD_SHIFT) / MOD_BASE;
   localparam int RECIP_PROD_W = 27;
   localparam int MOD_Q_W     = 8;
   localparam int MOD_R_W     = 6;
   localparam int FOLD_W      = MOD_R_W + MOD_SHIFT + 1;
   localparam logic signed [FOLD_W-1:0] DEG_90  = FOLD_W'(90 * 65536);
   localparam logic signed [FOLD_W-1:0] DEG_180 = FOLD_W'(180 * 65536);
   localparam logic signed [FOLD_W-1:0] DEG_270 = FOLD_W'(270 * 65536);
   localparam logic signed [FOLD_W-1:0] DEG_360 = FOLD_W'(360 * 65536);
   localparam int ANG_W = 24;

   // degrees to radians, Q2.30 result
   localparam int RAD_SHIFT = 16;
   localparam logic signed [25:0] DEG2RAD = 26'sd18740330;
   localparam int RAD_ROUND = 1 << (RAD_SHIFT - 1);

   // cordic
   localparam int TRIG_STAGES   = 24;
   localparam int CORDIC_STAGES = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;
   localparam int CRD_W         = 34;
   localparam int RAD_W         = RAD_SHIFT + CRD_W;
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // rotation
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int ROT_SHIFT = 31;
   localparam int ROT_W     = 34;
   localparam logic signed [SUM_W-1:0] ROT_ROUND = SUM_W'(64'sd1 <<< 30);
   localparam int SAT_IN_W  = 36;

   // corner signs, bit k set where the half extent is negative
   localparam logic [NUM_CORNERS-1:0] CORNER_X_NEG = 4'b1001;
   localparam logic [NUM_CORNERS-1:0] CORNER_Y_NEG = 4'b0011;

   typedef struct packed {
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] x;
   } pos_type;

   function automatic logic signed [CRD_W-1:0] stage_angle(input int i);
      logic signed [CRD_W-1:0] a;
      a = '0;
      case (i)
         0:       a = CRD_W'(32'h3243F6A8);
         1:       a = CRD_W'(32'h1DAC6705);
         2:       a = CRD_W'(32'h0FADBAFC);
         3:       a = CRD_W'(32'h07F56EA6);
         4:       a = CRD_W'(32'h03FEAB76);
         5:       a = CRD_W'(32'h01FFD55B);
         6:       a = CRD_W'(32'h00FFFAAA);
         7:       a = CRD_W'(32'h007FFF55);
         8:       a = CRD_W'(32'h003FFFEA);
         9:       a = CRD_W'(32'h001FFFFD);
         10:      a = CRD_W'(32'h000FFFFF);
         default: begin
            if (i <= 30) begin
               a = CRD_W'((64'sd1 <<< (30 - i)) - 64'sd1);
            end else begin
               a = '0;
            end
         end
      endcase
      return a;
   endfunction

   localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(64'sh7FFF_FFFF);
   localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(-64'sh8000_0000);

   function automatic logic signed [DATA_W-1:0] sat_word(
      input logic signed [SAT_IN_W-1:0] v
   );
      logic signed [DATA_W-1:0] r;
      r = v[DATA_W-1:0];
      if (v > SAT_HI) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < SAT_LO) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/box_vertex_world_transform_core.sv @@
// ----------------------------------------------------------------------------
// box_vertex_world_transform_core
// places the four corners of a box around a body pose: rotate by the body
// angle, add the body position, and give the edge to the next corner
// ----------------------------------------------------------------------------
// usage
//  req channel: one word per pose (pos_x, pos_y, angle_deg, all Q16.16).
//  rsp channel: four words per pose, corners 0..3, tlast on corner 3.
//  csr channel: index 0 box width, index 1 box height; csr_ready is always
//  high, write only while no pose is in flight.
//  path: the first corner of a pose comes out after the mod-360 reduction
//  and degree fold, radians, cordic, rotate, and edges and output word
//  stages; the other corners follow one per cycle while rsp_tready is high.
//  rate: the four rsp words per pose set the pose rate; the compute
//  pipeline itself takes a pose every cycle while it is not stalled.
//  reset: pipeline and output word empty, width and height back to 1.0.
//  stall: when the output word is held and the last stage is full, the whole
//  pipeline and req_tready hold; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module box_vertex_world_transform_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, angle_deg
   input  logic [bvwt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // vertex_index, world_x, world_y, edge_x, edge_y, zero pad
   output logic [bvwt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bvwt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bvwt_pkg::DIM_W-1:0]          csr_data
);
   import bvwt_pkg::*;

   localparam int CS         = CORDIC_STAGES;
   localparam int NUM_STAGES = 10 + CS;
   localparam int S_LAST     = NUM_STAGES - 1;

   // registers
   logic [DIM_W-1:0] box_width_ff, box_width_in;
   logic [DIM_W-1:0] box_height_ff, box_height_in;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic                  adv;
   logic                  ser_ready;
   logic                  ser_load;
   logic                  rsp_done;

   // input stage
   pos_type                  s0_pos_ff;
   logic signed [DATA_W-1:0] s0_ang_ff;

   // modulo stage
   logic signed [MOD_U_W:0]   u_sum;
   logic [MOD_U_W-1:0]        s1_u_in, s1_u_ff;
   logic [RECIP_PROD_W-1:0]   recip_prod;
   logic [MOD_Q_W-1:0]        s1_q_ff;
   logic [MOD_SHIFT-1:0]      s1_low_ff;
   pos_type                   s1_pos_ff;

   // remainder stage
   logic [MOD_U_W-1:0]   rem_raw;
   logic [MOD_R_W-1:0]   s2_rem_in, s2_rem_ff;
   logic [MOD_SHIFT-1:0] s2_low_ff;
   pos_type              s2_pos_ff;

   // fold stage
   logic signed [FOLD_W-1:0] deg_s;
   logic signed [ANG_W-1:0]  s3_z_in, s3_z_ff;
   logic                     s3_flip_in, s3_flip_ff;
   pos_type                  s3_pos_ff;

   // radian stage
   logic signed [RAD_W-1:0] s4_prod_in, s4_prod_ff;
   logic signed [RAD_W-1:0] rad_sum;
   logic                    s4_flip_ff;
   pos_type                 s4_pos_ff;

   // cordic stages
   logic signed [CRD_W-1:0] cx_ff [CS+1];
   logic signed [CRD_W-1:0] cy_ff [CS+1];
   logic signed [CRD_W-1:0] cz_ff [CS+1];
   logic                    cflip_ff [CS+1];
   pos_type                 cpos_ff [CS+1];

   // trig stage
   logic signed [CRD_W-1:0]  cos_full, sin_full;
   logic signed [DATA_W-1:0] trig_c_ff, trig_s_ff;
   pos_type                  trig_pos_ff;

   // product stage
   logic signed [DATA_W-1:0] wid_s, hgt_s;
   logic signed [PROD_W-1:0] p_wc_ff, p_ws_ff, p_hc_ff, p_hs_ff;
   pos_type                  prod_pos_ff;

   // rotate stage
   logic signed [SUM_W-1:0] sum_x [NUM_CORNERS];
   logic signed [SUM_W-1:0] sum_y [NUM_CORNERS];
   logic signed [ROT_W-1:0] rot_x_in [NUM_CORNERS];
   logic signed [ROT_W-1:0] rot_y_in [NUM_CORNERS];
   logic signed [ROT_W-1:0] rot_x_ff [NUM_CORNERS];
   logic signed [ROT_W-1:0] rot_y_ff [NUM_CORNERS];
   pos_type                 rot_pos_ff;

   // world stage
   logic signed [DATA_W-1:0] wld_x_in [NUM_CORNERS];
   logic signed [DATA_W-1:0] wld_y_in [NUM_CORNERS];
   logic signed [DATA_W-1:0] wld_x_ff [NUM_CORNERS];
   logic signed [DATA_W-1:0] wld_y_ff [NUM_CORNERS];

   // output word
   logic signed [DATA_W-1:0] out_ex_in [NUM_CORNERS];
   logic signed [DATA_W-1:0] out_ey_in [NUM_CORNERS];
   logic signed [DATA_W-1:0] out_wx_ff [NUM_CORNERS];
   logic signed [DATA_W-1:0] out_wy_ff [NUM_CORNERS];
   logic signed [DATA_W-1:0] out_ex_ff [NUM_CORNERS];
   logic signed [DATA_W-1:0] out_ey_ff [NUM_CORNERS];
   logic [CORNER_W-1:0]      idx_ff, idx_in;
   logic                     full_ff, full_in;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BOX_WIDTH:  box_width_in  = csr_data;
            CSR_BOX_HEIGHT: box_height_in = csr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff  <= BOX_RESET;
         box_height_ff <= BOX_RESET;
      end else begin
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

   // ------------------------------------------------------------------------
   // pipeline control
   // ------------------------------------------------------------------------
   assign rsp_done   = full_ff && rsp_tready && (idx_ff == LAST_CORNER);
   assign ser_ready  = !full_ff || rsp_done;
   assign adv        = ser_ready || !valid_ff[S_LAST];
   assign ser_load   = ser_ready && valid_ff[S_LAST];
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------------------
   // input and angle reduction
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_pos_ff.x <= req_tdata[DATA_W-1:0];
         s0_pos_ff.y <= req_tdata[2*DATA_W-1:DATA_W];
         s0_ang_ff   <= req_tdata[3*DATA_W-1:2*DATA_W];
      end
   end

   // floor quotient by 45 of the offset upper angle bits, may be one low
   always_comb begin
      u_sum      = (MOD_U_W+1)'(signed'(s0_ang_ff[DATA_W-1:MOD_SHIFT]))
                 + (MOD_U_W+1)'(MOD_OFFSET);
      s1_u_in    = u_sum[MOD_U_W-1:0];
      recip_prod = RECIP_PROD_W'(s1_u_in) * RECIP_PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_u_ff   <= s1_u_in;
         s1_q_ff   <= recip_prod[RECIP_PROD_W-1:MOD_SHIFT];
         s1_low_ff <= s0_ang_ff[MOD_SHIFT-1:0];
         s1_pos_ff <= s0_pos_ff;
      end
   end

   always_comb begin
      rem_raw = s1_u_ff - MOD_U_W'(s1_q_ff) * MOD_U_W'(MOD_BASE);
      if (rem_raw >= MOD_U_W'(MOD_BASE)) begin
         s2_rem_in = MOD_R_W'(rem_raw - MOD_U_W'(MOD_BASE));
      end else begin
         s2_rem_in = MOD_R_W'(rem_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_rem_ff <= s2_rem_in;
         s2_low_ff <= s1_low_ff;
         s2_pos_ff <= s1_pos_ff;
      end
   end

   // fold [0, 360) into [-90, 90] with a sign flip
   always_comb begin
      deg_s      = signed'({1'b0, s2_rem_ff, s2_low_ff});
      s3_flip_in = 1'b0;
      if (deg_s <= DEG_90) begin
         s3_z_in = ANG_W'(deg_s);
      end else if (deg_s < DEG_270) begin
         s3_z_in    = ANG_W'(deg_s - DEG_180);
         s3_flip_in = 1'b1;
      end else begin
         s3_z_in = ANG_W'(deg_s - DEG_360);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_z_ff    <= s3_z_in;
         s3_flip_ff <= s3_flip_in;
         s3_pos_ff  <= s2_pos_ff;
      end
   end

   assign s4_prod_in = RAD_W'(s3_z_ff) * RAD_W'(DEG2RAD);

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_prod_ff <= s4_prod_in;
         s4_flip_ff <= s3_flip_ff;
         s4_pos_ff  <= s3_pos_ff;
      end
   end

   // ------------------------------------------------------------------------
   // cordic, one rotation per stage
   // ------------------------------------------------------------------------
   assign rad_sum = s4_prod_ff + RAD_W'(RAD_ROUND);

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]    <= CORDIC_GAIN;
         cy_ff[0]    <= '0;
         cz_ff[0]    <= rad_sum[RAD_W-1:RAD_SHIFT];
         cflip_ff[0] <= s4_flip_ff;
         cpos_ff[0]  <= s4_pos_ff;
      end
   end

   for (genvar j = 0; j < CS; j++) begin : g_cordic
      logic signed [CRD_W-1:0] dx, dy, x_in, y_in, z_in;

      always_comb begin
         dx = cy_ff[j] >>> j;
         dy = cx_ff[j] >>> j;
         if (!cz_ff[j][CRD_W-1]) begin
            x_in = cx_ff[j] - dx;
            y_in = cy_ff[j] + dy;
            z_in = cz_ff[j] - stage_angle(j);
         end else begin
            x_in = cx_ff[j] + dx;
            y_in = cy_ff[j] - dy;
            z_in = cz_ff[j] + stage_angle(j);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[j+1]    <= x_in;
            cy_ff[j+1]    <= y_in;
            cz_ff[j+1]    <= z_in;
            cflip_ff[j+1] <= cflip_ff[j];
            cpos_ff[j+1]  <= cpos_ff[j];
         end
      end
   end

   always_comb begin
      cos_full = cflip_ff[CS] ? -cx_ff[CS] : cx_ff[CS];
      sin_full = cflip_ff[CS] ? -cy_ff[CS] : cy_ff[CS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trig_c_ff   <= cos_full[DATA_W-1:0];
         trig_s_ff   <= sin_full[DATA_W-1:0];
         trig_pos_ff <= cpos_ff[CS];
      end
   end

   // ------------------------------------------------------------------------
   // rotate and translate
   // ------------------------------------------------------------------------
   assign wid_s = signed'({1'b0, box_width_ff});
   assign hgt_s = signed'({1'b0, box_height_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         p_wc_ff     <= PROD_W'(wid_s) * PROD_W'(trig_c_ff);
         p_ws_ff     <= PROD_W'(wid_s) * PROD_W'(trig_s_ff);
         p_hc_ff     <= PROD_W'(hgt_s) * PROD_W'(trig_c_ff);
         p_hs_ff     <= PROD_W'(hgt_s) * PROD_W'(trig_s_ff);
         prod_pos_ff <= trig_pos_ff;
      end
   end

   // halves come for free: the product is taken as Q47 and shifted by 31
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         sum_x[k] = (CORNER_X_NEG[k] ? -SUM_W'(p_wc_ff) : SUM_W'(p_wc_ff))
                  + (CORNER_Y_NEG[k] ? SUM_W'(p_hs_ff) : -SUM_W'(p_hs_ff))
                  + ROT_ROUND;
         sum_y[k] = (CORNER_X_NEG[k] ? -SUM_W'(p_ws_ff) : SUM_W'(p_ws_ff))
                  + (CORNER_Y_NEG[k] ? -SUM_W'(p_hc_ff) : SUM_W'(p_hc_ff))
                  + ROT_ROUND;
         rot_x_in[k] = sum_x[k][ROT_SHIFT+ROT_W-1:ROT_SHIFT];
         rot_y_in[k] = sum_y[k][ROT_SHIFT+ROT_W-1:ROT_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_x_ff   <= rot_x_in;
         rot_y_ff   <= rot_y_in;
         rot_pos_ff <= prod_pos_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         wld_x_in[k] = sat_word(SAT_IN_W'(rot_x_ff[k]) + SAT_IN_W'(rot_pos_ff.x));
         wld_y_in[k] = sat_word(SAT_IN_W'(rot_y_ff[k]) + SAT_IN_W'(rot_pos_ff.y));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wld_x_ff <= wld_x_in;
         wld_y_ff <= wld_y_in;
      end
   end

   // ------------------------------------------------------------------------
   // edges and output word
   // ------------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         out_ex_in[k] = sat_word(SAT_IN_W'(wld_x_ff[(k + 1) % NUM_CORNERS])
                               - SAT_IN_W'(wld_x_ff[k]));
         out_ey_in[k] = sat_word(SAT_IN_W'(wld_y_ff[(k + 1) % NUM_CORNERS])
                               - SAT_IN_W'(wld_y_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         out_wx_ff <= wld_x_ff;
         out_wy_ff <= wld_y_ff;
         out_ex_ff <= out_ex_in;
         out_ey_ff <= out_ey_in;
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      full_in = full_ff;
      if (full_ff && rsp_tready) begin
         idx_in = idx_ff + CORNER_W'(1);
      end
      if (ser_load) begin
         full_in = 1'b1;
      end else if (rsp_done) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         full_ff <= full_in;
      end
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tlast  = (idx_ff == LAST_CORNER);
   assign rsp_tdata  = RSP_DATA_W'({out_ey_ff[idx_ff], out_ex_ff[idx_ff],
                                    out_wy_ff[idx_ff], out_wx_ff[idx_ff], idx_ff});

endmodule

@@ rtl/core/bvwt_checker.sv @@
// ----------------------------------------------------------------------------
// bvwt_checker
// port level checks on the result stream of the box vertex transform core
// ----------------------------------------------------------------------------
module bvwt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bvwt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import bvwt_pkg::*;

   // held word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // corners of one pose come back to back in order
   a_corner_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid &&
         rsp_tdata[CORNER_W-1:0] == CORNER_W'($past(rsp_tdata[CORNER_W-1:0]) + 2'd1))
      else $error("corner sequence broken");

   // tlast marks the last corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata[CORNER_W-1:0] == LAST_CORNER))
      else $error("tlast not on last corner");

   // empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind box_vertex_world_transform_core bvwt_checker u_bvwt_checker (.*);

@@ tb/sv/bvwt_corner_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvwt_corner_checker
// watches the pose, corner and register channels of the box vertex world
// transform core, keeps its own copy of the box size, predicts the four
// corner words of every accepted pose and compares each corner word that
// leaves the core against the oldest prediction
// ----------------------------------------------------------------------------
module bvwt_corner_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [bvwt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [bvwt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bvwt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bvwt_pkg::DIM_W-1:0]          csr_data,
   output int unsigned                         fail_count,
   output int unsigned                         pending_count,
   output int unsigned                         pose_count,
   output int unsigned                         corner_count
);
   import bvwt_pkg::*;

   localparam int     W          = DATA_W;
   localparam int     ROT_STAGES = CORDIC_STAGES;
   localparam longint FULL_TURN  = 64'sd360 * 65536;
   localparam longint HALF_TURN  = 64'sd180 * 65536;
   localparam longint QTR_TURN   = 64'sd90 * 65536;
   localparam longint RAD_PER_DEG = 64'sd18740330;
   localparam longint UNIT_GAIN  = 64'sd652032874;
   localparam longint WORD_MAX   = 64'sd2147483647;
   localparam longint WORD_MIN   = -64'sd2147483648;

   typedef struct packed {
      logic [CORNER_W-1:0] idx;
      logic [W-1:0]        wx;
      logic [W-1:0]        wy;
      logic [W-1:0]        ex;
      logic [W-1:0]        ey;
      logic                last;
   } corner_word_t;

   logic [DIM_W-1:0] box_w;
   logic [DIM_W-1:0] box_h;
   corner_word_t     expected_corners[$];
   corner_word_t     seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      pose_count    = 0;
      corner_count  = 0;
      box_w         = BOX_RESET;
      box_h         = BOX_RESET;
   end

   function automatic longint atan_step(input int i);
      longint a;
      case (i)
         0:  a = 64'h3243F6A8;
         1:  a = 64'h1DAC6705;
         2:  a = 64'h0FADBAFC;
         3:  a = 64'h07F56EA6;
         4:  a = 64'h03FEAB76;
         5:  a = 64'h01FFD55B;
         6:  a = 64'h00FFFAAA;
         7:  a = 64'h007FFF55;
         8:  a = 64'h003FFFEA;
         9:  a = 64'h001FFFFD;
         10: a = 64'h000FFFFF;
         default: a = (i <= 30) ? ((64'sd1 <<< (30 - i)) - 64'sd1) : 64'sd0;
      endcase
      return a;
   endfunction

   function automatic logic [W-1:0] clamp_word(input longint v);
      longint r;
      r = v;
      if (v > WORD_MAX) r = WORD_MAX;
      if (v < WORD_MIN) r = WORD_MIN;
      return r[W-1:0];
   endfunction

   // cosine and sine in Q2.30 of an angle in Q16.16 degrees
   function automatic void unit_vector(input longint deg, output longint c,
                                       output longint s);
      longint r, x, y, z, dx, dy;
      bit     flip;
      r = deg % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      if (r > HALF_TURN) r -= FULL_TURN;
      flip = 1'b0;
      if (r > QTR_TURN) begin
         r -= HALF_TURN;
         flip = 1'b1;
      end else if (r < -QTR_TURN) begin
         r += HALF_TURN;
         flip = 1'b1;
      end
      z = (r * RAD_PER_DEG + 64'sd32768) >>> 16;
      x = UNIT_GAIN;
      y = 0;
      for (int i = 0; i < ROT_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_step(i);
         end else begin
            x += dx;
            y -= dy;
            z += atan_step(i);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   task automatic predict_corners(input longint px, input longint py,
                                  input longint ang);
      longint       c, s, vx, vy, rx, ry;
      longint       wx[4];
      longint       wy[4];
      corner_word_t w;
      int           n;
      unit_vector(ang, c, s);
      for (int k = 0; k < NUM_CORNERS; k++) begin
         vx = longint'(box_w);
         vy = longint'(box_h);
         if (k == 0 || k == 3) vx = -vx;
         if (k == 0 || k == 1) vy = -vy;
         rx = (vx * c - vy * s + (64'sd1 <<< 30)) >>> 31;
         ry = (vx * s + vy * c + (64'sd1 <<< 30)) >>> 31;
         wx[k] = longint'($signed(clamp_word(rx + px)));
         wy[k] = longint'($signed(clamp_word(ry + py)));
      end
      for (int k = 0; k < NUM_CORNERS; k++) begin
         n      = (k + 1) % NUM_CORNERS;
         w.idx  = CORNER_W'(k);
         w.wx   = wx[k][W-1:0];
         w.wy   = wy[k][W-1:0];
         w.ex   = clamp_word(wx[n] - wx[k]);
         w.ey   = clamp_word(wy[n] - wy[k]);
         w.last = (CORNER_W'(k) == LAST_CORNER);
         expected_corners.push_back(w);
      end
      pose_count++;
   endtask

   task automatic check_corner(input corner_word_t got);
      corner_word_t want;
      if (expected_corners.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected corner word: idx %0d x %h y %h ex %h ey %h last %b",
                     got.idx, got.wx, got.wy, got.ex, got.ey, got.last);
      end else begin
         want = expected_corners.pop_front();
         corner_count++;
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("corner mismatch at %0t", $realtime);
               $display("  want idx %0d x %h y %h ex %h ey %h last %b",
                        want.idx, want.wx, want.wy, want.ex, want.ey, want.last);
               $display("  got  idx %0d x %h y %h ex %h ey %h last %b",
                        got.idx, got.wx, got.wy, got.ex, got.ey, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         box_w = BOX_RESET;
         box_h = BOX_RESET;
         expected_corners.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.idx  = rsp_tdata[0 +: CORNER_W];
            seen.wx   = rsp_tdata[CORNER_W +: W];
            seen.wy   = rsp_tdata[CORNER_W + W +: W];
            seen.ex   = rsp_tdata[CORNER_W + 2 * W +: W];
            seen.ey   = rsp_tdata[CORNER_W + 3 * W +: W];
            seen.last = rsp_tlast;
            check_corner(seen);
         end
         if (req_tvalid && req_tready)
            predict_corners(longint'($signed(req_tdata[0 +: W])),
                            longint'($signed(req_tdata[W +: W])),
                            longint'($signed(req_tdata[2 * W +: W])));
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_BOX_WIDTH:  box_w = csr_data;
               CSR_BOX_HEIGHT: box_h = csr_data;
               default: ;
            endcase
         end
      end
      pending_count = expected_corners.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression for the box vertex world transform core: directed poses at the
// angle folds and position extremes, then random poses under a range of box
// sizes and idle patterns on both stream sides; a checker beside the core
// predicts every corner word and counts mismatches
// ----------------------------------------------------------------------------
module tb;
   import bvwt_pkg::*;

   localparam int DEG     = 65536;
   localparam int POS_MAX = 32'h7FFF_FFFF;
   localparam int POS_MIN = 32'h8000_0000;
   localparam logic [DIM_W-1:0] DIM_MAX = {DIM_W{1'b1}};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // pos_x, pos_y, angle_deg
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // vertex_index, world_x, world_y, edge_x, edge_y, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DIM_W-1:0]      csr_data = '0;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned pose_count;
   int unsigned corner_count;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
   end

   box_vertex_world_transform_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bvwt_corner_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .pose_count    (pose_count),
      .corner_count  (corner_count)
   );

   // called at a falling edge, returns at a falling edge
   task automatic send_pose(input int px, input int py, input int ang);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {ang, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_box(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      csr_valid = 1'b1;
      csr_index = CSR_BOX_WIDTH;
      csr_data  = w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index = CSR_BOX_HEIGHT;
      csr_data  = h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain;
      int n;
      req_tvalid = 1'b0;
      n = 0;
      while (pending_count != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 51; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
         default: begin req_idle_pct = 15; rsp_stall_pct = 15; end
      endcase
   endtask

   function automatic int rand_position();
      int v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = int'($urandom_range(0, 2000 * DEG)) - 1000 * DEG;
         2: v = POS_MAX - int'($urandom_range(0, 8 * DEG));
         3: v = POS_MIN + int'($urandom_range(0, 8 * DEG));
         default: v = int'($urandom_range(0, 200 * DEG)) - 100 * DEG;
      endcase
      return v;
   endfunction

   function automatic int rand_angle();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = (int'($urandom_range(0, 16)) - 8) * 90 * DEG
                + int'($urandom_range(0, 4)) - 2;
         2: v = int'($urandom_range(0, 1440 * DEG)) - 720 * DEG;
         default: v = int'($urandom_range(0, 360 * DEG)) - 180 * DEG;
      endcase
      return v;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // unit box at reset size: quadrant folds, wrap and position extremes
      set_idle(0);
      send_pose(0, 0, 0);
      send_pose(0, 0, 90 * DEG);
      send_pose(0, 0, -90 * DEG);
      send_pose(0, 0, 90 * DEG + 1);
      send_pose(0, 0, -90 * DEG - 1);
      send_pose(0, 0, 180 * DEG);
      send_pose(0, 0, -180 * DEG);
      send_pose(0, 0, 180 * DEG + 1);
      send_pose(5 * DEG + DEG / 2, -3 * DEG - DEG / 4, 270 * DEG);
      send_pose(0, 0, 360 * DEG);
      send_pose(0, 0, 720 * DEG + DEG / 2);
      send_pose(POS_MAX, POS_MIN, 45 * DEG);
      send_pose(POS_MIN, POS_MAX, POS_MAX);
      send_pose(-1, 1, POS_MIN);
      drain();

      // largest box: corner and edge saturation
      write_box(DIM_MAX, DIM_MAX);
      send_pose(0, 0, 0);
      send_pose(POS_MAX, POS_MAX, 45 * DEG);
      send_pose(POS_MIN, POS_MIN, -135 * DEG);
      send_pose(POS_MAX, POS_MIN, 90 * DEG);
      send_pose(0, 0, 30 * DEG);
      send_pose(POS_MIN, 0, 180 * DEG);
      send_pose(0, POS_MAX, POS_MAX);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_box('0, '0);
            1: write_box(DIM_MAX, DIM_MAX);
            2: write_box(DIM_MAX, '0);
            3: write_box('0, DIM_MAX);
            4: write_box(DIM_W'(3 * DEG), DIM_W'(2 * DEG));
            5: write_box(DIM_W'($urandom), DIM_W'($urandom));
            6: write_box(DIM_W'($urandom_range(0, 64 * DEG)),
                         DIM_W'($urandom_range(0, 64 * DEG)));
            default: write_box(DIM_W'($urandom), DIM_W'($urandom_range(0, 8 * DEG)));
         endcase
         set_idle(ph % 4);
         repeat (25) send_pose(rand_position(), rand_position(), rand_angle());
         drain();
      end

      repeat (40) @(negedge clock);
      $display("covered %0d poses and %0d corner words over ten box sizes",
               pose_count, corner_count);
      $display("(zero and full width included) under four idle patterns");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
